/* design/khgr_pkg.sv */
// Package for the key hash group router.
// Holds field widths, the hash seed, request kind codes and the controller state type.
// No dependencies.
package khgr_pkg;

	localparam int KIND_W  = 2;
	localparam int BYTE_W  = 8;
	localparam int GRP_W   = 15;
	localparam int HASH_W  = 17;
	localparam int MULT_W  = BYTE_W + 1;
	localparam int PROD_W  = HASH_W + MULT_W;

	localparam logic [HASH_W-1:0] HASH_SEED = 17'd104729;

	localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_MOD,
		ST_DONE
	} state_t;

endpackage

/* design/key_hash_group_router_top.sv */
// Key hash group router: one key byte per item, one result per finished key.
// A nonzero byte stalls the input while it passes through the multiplier and then the remainder unit;
// a last byte then also waits until the output register is free and loads its result into it.
// An empty key or a last zero byte passes through the remainder unit only, then loads the output;
// other zero bytes do not stall the input. A result waits in the output register while the next item
// is accepted. Reset clears the control state, sets the hash to its seed and group_count to 1.
module key_hash_group_router_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [khgr_pkg::GRP_W-1:0]    cfg_wr_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [khgr_pkg::KIND_W-1:0]   request_kind,
	input  logic [khgr_pkg::BYTE_W-1:0]   key_byte,
	input  logic [khgr_pkg::BYTE_W-1:0]   bytes_after,
	input  logic                          first_byte,
	input  logic                          last_byte,
	input  logic                          empty_key,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          broadcast_all,
	output logic [khgr_pkg::GRP_W-1:0]    group
);
	import khgr_pkg::*;

	state_t              state_q;
	state_t              state_d;
	logic [GRP_W-1:0]    group_count_q;
	logic [GRP_W-1:0]    eff_groups;
	logic [HASH_W-1:0]   hash_q;
	logic [KIND_W-1:0]   kind_q;
	logic                emit_q;
	logic                upd_q;
	logic                out_valid_q;
	logic                bcast_q;
	logic [GRP_W-1:0]    group_q;

	logic                in_acc;
	logic                restart;
	logic                use_mul;
	logic                do_emit;
	logic [HASH_W-1:0]   start_hash;
	logic [MULT_W-1:0]   mult_in;
	logic                mul_start;
	logic                mul_done;
	logic [PROD_W-1:0]   product;
	logic                mod_start;
	logic                mod_done;
	logic [PROD_W-1:0]   mod_value;
	logic [GRP_W-1:0]    remainder;
	logic                out_free;
	logic                out_load;
	logic                is_bcast;

	assign eff_groups = (group_count_q == '0) ? GRP_W'(1) : group_count_q;
	assign in_acc     = in_valid && !in_stall;
	assign restart    = empty_key || first_byte;
	assign use_mul    = !empty_key && (key_byte != '0);
	assign do_emit    = empty_key || last_byte;
	assign start_hash = restart ? HASH_SEED : hash_q;
	assign mult_in    = MULT_W'(key_byte) + MULT_W'(bytes_after);
	assign mod_value  = mul_done ? product : PROD_W'(start_hash);
	assign out_free   = !out_valid_q || !out_stall;
	assign is_bcast   = (kind_q == KIND_CREATE) || (kind_q == KIND_DELETE);

	khgr_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (start_hash),
		.mplier  (mult_in),
		.done    (mul_done),
		.product (product)
	);

	khgr_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.value     (mod_value),
		.divisor   (eff_groups),
		.done      (mod_done),
		.remainder (remainder)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (use_mul) begin
						state_d = ST_MUL;
					end else if (do_emit) begin
						state_d = ST_MOD;
					end
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					state_d = ST_MOD;
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					state_d = emit_q ? ST_DONE : ST_IDLE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		mul_start = 1'b0;
		mod_start = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall  = 1'b0;
				mul_start = in_valid && use_mul;
				mod_start = in_valid && !use_mul && do_emit;
			end
			ST_MUL: begin
				mod_start = mul_done;
			end
			ST_MOD: begin
			end
			ST_DONE: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			group_count_q <= GRP_W'(1);
			hash_q        <= HASH_SEED;
			kind_q        <= KIND_CREATE;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				group_count_q <= cfg_wr_data;
			end
			if (in_acc) begin
				if (restart) begin
					hash_q <= HASH_SEED;
					kind_q <= request_kind;
				end
			end else if (mod_done && upd_q) begin
				hash_q <= HASH_W'(remainder);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			emit_q <= do_emit;
			upd_q  <= use_mul;
		end
		if (out_load) begin
			bcast_q <= is_bcast;
			group_q <= is_bcast ? '0 : remainder + GRP_W'(1);
		end
	end

	assign out_valid     = out_valid_q;
	assign broadcast_all = bcast_q;
	assign group         = group_q;

endmodule

/* design/khgr_mul.sv */
// Bit-serial multiplier for the key hash group router.
// Takes one multiplier bit per cycle, most significant first; depends on khgr_pkg.
module khgr_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [khgr_pkg::HASH_W-1:0]  mcand,
	input  logic [khgr_pkg::MULT_W-1:0]  mplier,
	output logic                         done,
	output logic [khgr_pkg::PROD_W-1:0]  product
);
	import khgr_pkg::*;

	localparam int CNT_W = $clog2(MULT_W + 1);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(MULT_W - 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [HASH_W-1:0]   mcand_q;
	logic [MULT_W-1:0]   mplier_q;
	logic [PROD_W-1:0]   acc_q;
	logic [PROD_W-1:0]   addend;

	assign addend  = mplier_q[MULT_W-1] ? PROD_W'(mcand_q) : '0;
	assign product = acc_q;
	assign done    = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= mcand;
			mplier_q <= mplier;
			acc_q    <= '0;
		end else if (busy_q) begin
			acc_q    <= {acc_q[PROD_W-2:0], 1'b0} + addend;
			mplier_q <= {mplier_q[MULT_W-2:0], 1'b0};
		end
	end

endmodule

/* design/khgr_mod.sv */
// Bit-serial restoring remainder unit for the key hash group router.
// Reduces its input value modulo the group count one bit per cycle; depends on khgr_pkg.
module khgr_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [khgr_pkg::PROD_W-1:0]  value,
	input  logic [khgr_pkg::GRP_W-1:0]   divisor,
	output logic                         done,
	output logic [khgr_pkg::GRP_W-1:0]   remainder
);
	import khgr_pkg::*;

	localparam int CNT_W = $clog2(PROD_W + 1);
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(PROD_W - 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PROD_W-1:0]   val_q;
	logic [GRP_W-1:0]    div_q;
	logic [GRP_W-1:0]    rem_q;
	logic [GRP_W:0]      trial;
	logic [GRP_W:0]      diff;

	assign trial     = {rem_q, val_q[PROD_W-1]};
	assign diff      = trial - {1'b0, div_q};
	assign remainder = rem_q;
	assign done      = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == LAST_STEP);
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= value;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[PROD_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				rem_q <= diff[GRP_W-1:0];
			end else begin
				rem_q <= trial[GRP_W-1:0];
			end
		end
	end

endmodule

/* design/khgr_checker.sv */
// Port-level checker for the key hash group router, bound to the top level.
// Depends on khgr_pkg and on the port names of key_hash_group_router_top.
module khgr_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          empty_key,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic                          broadcast_all,
	input  logic [khgr_pkg::GRP_W-1:0]    group
);
	import khgr_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(broadcast_all) && $stable(group))
		else $error("stalled output item changed");

	a_bcast_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && broadcast_all |-> group == '0)
		else $error("broadcast item carries a group");

	a_hashed_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !broadcast_all |-> group != '0)
		else $error("hashed item has group zero");

	a_empty_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && empty_key |=> in_stall)
		else $error("empty key item did not start the remainder pass");

endmodule

bind key_hash_group_router_top khgr_checker u_khgr_checker (.*);

/* verif/testbench.sv */
// Self-checking testbench for key_hash_group_router_top.
// Streams key bytes through the block and checks each routing result against a local hash model.
// Depends on khgr_pkg and key_hash_group_router_top.
module testbench;
	import khgr_pkg::*;

	localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int IDLE_PCT      = 37;
	localparam int HOLD_CYCLES   = 600;
	localparam int SETTLE_CYCLES = 60;
	localparam int STALL_LIMIT   = 5000;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] kbyte;
		logic [BYTE_W-1:0] after;
		logic              first_b;
		logic              last_b;
		logic              empty_k;
	} key_item_t;

	typedef struct {
		logic             bcast;
		logic [GRP_W-1:0] grp;
	} route_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [GRP_W-1:0]  cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [KIND_W-1:0] request_kind = '0;
	logic [BYTE_W-1:0] key_byte = '0;
	logic [BYTE_W-1:0] bytes_after = '0;
	logic              first_byte = 1'b0;
	logic              last_byte = 1'b0;
	logic              empty_key = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              broadcast_all;
	logic [GRP_W-1:0]  group;

	key_item_t pending_items[$];
	route_t    route_expect[$];
	key_item_t next_item;

	logic [HASH_W-1:0] hash_now = HASH_SEED;
	logic [KIND_W-1:0] kind_now = KIND_CREATE;
	logic [GRP_W-1:0]  group_cfg = 15'd1;

	logic in_taken = 1'b0;
	bit   no_idle = 1'b0;
	bit   long_hold = 1'b0;
	int   hold_count = 0;
	int   idle_run = 0;
	int   error_count = 0;
	wire  hold_done = (hold_count == HOLD_CYCLES);

	key_hash_group_router_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.request_kind (request_kind),
		.key_byte     (key_byte),
		.bytes_after  (bytes_after),
		.first_byte   (first_byte),
		.last_byte    (last_byte),
		.empty_key    (empty_key),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.broadcast_all(broadcast_all),
		.group        (group)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	function automatic route_t route_for(input logic [KIND_W-1:0] k, input logic [HASH_W-1:0] h);
		route_t r;
		int unsigned groups;
		groups = (group_cfg == 0) ? 1 : group_cfg;
		if (k == KIND_CREATE || k == KIND_DELETE) begin
			r.bcast = 1'b1;
			r.grp = '0;
		end else begin
			r.bcast = 1'b0;
			r.grp = GRP_W'((32'(h) % groups) + 1);
		end
		return r;
	endfunction

	function automatic bit hash_key_byte(input key_item_t it, output route_t res);
		int unsigned prod;
		int unsigned groups;
		groups = (group_cfg == 0) ? 1 : group_cfg;
		if (it.empty_k) begin
			kind_now = it.kind;
			hash_now = HASH_SEED;
			res = route_for(kind_now, hash_now);
			return 1'b1;
		end
		if (it.first_b) begin
			hash_now = HASH_SEED;
			kind_now = it.kind;
		end
		if (it.kbyte != 0) begin
			prod = 32'(hash_now) * (32'(it.kbyte) + 32'(it.after));
			hash_now = HASH_W'(prod % groups);
		end
		if (it.last_b) begin
			res = route_for(kind_now, hash_now);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Results are checked before the newly accepted item is hashed, all in one process.
	always @(posedge clk) begin : port_monitor
		key_item_t seen;
		route_t    got_route;
		route_t    want;
		bit        took_in;
		bit        took_out;
		took_in = arst_n && in_valid && !in_stall;
		took_out = arst_n && (out_valid === 1'b1) && !out_stall;
		if (took_out) begin
			if (route_expect.size() == 0) begin
				report_mismatch("result with no expectation waiting");
			end else begin
				want = route_expect.pop_front();
				if (broadcast_all !== want.bcast)
					report_mismatch($sformatf("broadcast_all %b, expected %b",
						broadcast_all, want.bcast));
				if (group !== want.grp)
					report_mismatch($sformatf("group %0d, expected %0d", group, want.grp));
			end
		end
		if (took_in) begin
			seen.kind = request_kind;
			seen.kbyte = key_byte;
			seen.after = bytes_after;
			seen.first_b = first_byte;
			seen.last_b = last_byte;
			seen.empty_k = empty_key;
			if (hash_key_byte(seen, got_route))
				route_expect.push_back(got_route);
		end
		in_taken <= took_in;
		if (took_in || took_out)
			idle_run <= 0;
		else
			idle_run <= idle_run + 1;
		if (idle_run >= STALL_LIMIT) begin
			$display("key_hash_group_router_top test failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(in_valid && !in_taken)) begin
			if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
				next_item = pending_items.pop_front();
				in_valid <= 1'b1;
				request_kind <= next_item.kind;
				key_byte <= next_item.kbyte;
				bytes_after <= next_item.after;
				first_byte <= next_item.first_b;
				last_byte <= next_item.last_b;
				empty_key <= next_item.empty_k;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (long_hold) begin
			if (hold_count < HOLD_CYCLES) begin
				out_stall <= 1'b1;
				hold_count <= hold_count + 1;
			end else begin
				out_stall <= 1'b0;
			end
		end else begin
			hold_count <= 0;
			out_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
		end
	end

	task automatic add_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] kb,
			input logic [BYTE_W-1:0] after, input logic f, input logic l, input logic e);
		key_item_t it;
		it.kind = kind;
		it.kbyte = kb;
		it.after = after;
		it.first_b = f;
		it.last_b = l;
		it.empty_k = e;
		pending_items.push_back(it);
	endtask

	function automatic logic [KIND_W-1:0] pick_kind();
		return ($urandom_range(9) < 5) ? KIND_OTHER : KIND_W'($urandom_range(3));
	endfunction

	task automatic add_key(input int len, input logic [KIND_W-1:0] kind, input bit drop_first);
		logic [BYTE_W-1:0] kb;
		for (int i = 0; i < len; i++) begin
			kb = ($urandom_range(99) < 15) ? '0 : BYTE_W'($urandom_range(255));
			add_item(kind, kb, BYTE_W'(len - 1 - i), (i == 0) && !drop_first, i == len - 1, 1'b0);
		end
	endtask

	// Mostly well-formed keys, with empty keys, broken keys and random noise mixed in.
	task automatic add_traffic(input int n);
		int made;
		int pick;
		int len;
		made = 0;
		@(posedge clk);
		while (made < n) begin
			pick = $urandom_range(99);
			if (pick < 78) begin
				len = ($urandom_range(19) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
				add_key(len, pick_kind(), $urandom_range(19) == 0);
				made += len;
			end else if (pick < 88) begin
				add_item(KIND_W'($urandom_range(3)), BYTE_W'($urandom_range(255)),
					BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)), 1'b1);
				made++;
			end else begin
				add_item(KIND_W'($urandom_range(3)), BYTE_W'($urandom_range(255)),
					BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
					1'($urandom_range(1)), $urandom_range(9) == 0);
				made++;
			end
		end
	endtask

	task automatic drain_all();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || in_valid || route_expect.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_groups(input logic [GRP_W-1:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		group_cfg = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_groups(15'd32767);

		@(posedge clk);
		add_item(KIND_CREATE, 8'hFF, 8'd0, 1'b1, 1'b1, 1'b1);
		add_item(KIND_DELETE, 8'h01, 8'd3, 1'b0, 1'b0, 1'b1);
		add_item(KIND_OTHER, 8'h00, 8'd0, 1'b0, 1'b1, 1'b1);
		add_item(KIND_SPARE, 8'hA5, 8'hFF, 1'b1, 1'b0, 1'b1);
		add_item(KIND_OTHER, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b0);
		add_item(KIND_SPARE, 8'h01, 8'd0, 1'b1, 1'b1, 1'b0);
		add_item(KIND_OTHER, 8'h00, 8'd0, 1'b1, 1'b1, 1'b0);
		add_item(KIND_CREATE, 8'h80, 8'd1, 1'b1, 1'b0, 1'b0);
		add_item(KIND_OTHER, 8'h7F, 8'd0, 1'b0, 1'b1, 1'b0);
		add_item(KIND_DELETE, 8'h33, 8'd1, 1'b1, 1'b0, 1'b0);
		add_item(KIND_DELETE, 8'hCC, 8'd0, 1'b0, 1'b1, 1'b0);
		add_item(KIND_OTHER, 8'h55, 8'd2, 1'b1, 1'b0, 1'b0);
		add_item(KIND_OTHER, 8'h00, 8'd1, 1'b0, 1'b0, 1'b0);
		add_item(KIND_OTHER, 8'hAA, 8'd0, 1'b0, 1'b1, 1'b0);
		add_item(KIND_OTHER, 8'h10, 8'd1, 1'b0, 1'b0, 1'b0);
		add_item(KIND_OTHER, 8'h20, 8'd0, 1'b0, 1'b1, 1'b0);
		add_item(KIND_CREATE, 8'h03, 8'd0, 1'b0, 1'b1, 1'b0);
		add_item(KIND_SPARE, 8'h42, 8'd1, 1'b1, 1'b0, 1'b0);
		add_item(KIND_DELETE, 8'h99, 8'd7, 1'b0, 1'b0, 1'b1);
		add_item(KIND_OTHER, 8'h42, 8'd0, 1'b0, 1'b1, 1'b0);
		drain_all();

		set_groups(15'd1);
		add_traffic(120);
		drain_all();

		set_groups(15'd0);
		add_traffic(80);
		drain_all();

		set_groups(15'd32767);
		@(posedge clk);
		long_hold = 1'b1;
		add_traffic(120);
		while (!hold_done)
			@(posedge clk);
		long_hold = 1'b0;
		drain_all();

		set_groups(GRP_W'($urandom_range(32767, 1)));
		@(posedge clk);
		no_idle = 1'b1;
		add_traffic(200);
		drain_all();
		no_idle = 1'b0;

		set_groups(GRP_W'($urandom_range(16, 2)));
		add_traffic(150);
		drain_all();

		set_groups(GRP_W'($urandom_range(32767, 1)));
		@(posedge clk);
		add_key(256, KIND_OTHER, 1'b0);
		add_traffic(100);
		drain_all();

		if (error_count == 0)
			$display("key_hash_group_router_top test passed");
		else
			$display("key_hash_group_router_top test failed");
		$finish;
	end

endmodule
